FILE: hw/rtl/asip_pkg.sv
`timescale 1ns / 1ps
// Package for the ASCII signed integer parser: widths, character codes,
// parse phase encoding and the structs passed between modules. No dependencies.
package asip_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 32;
  localparam int unsigned CHAR_WIDTH  = 8;

  localparam logic [CHAR_WIDTH-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_X_LOW  = 8'h78;
  localparam logic [CHAR_WIDTH-1:0] CH_X_UP   = 8'h58;
  localparam logic [CHAR_WIDTH-1:0] CH_A_LOW  = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_F_LOW  = 8'h66;
  localparam logic [CHAR_WIDTH-1:0] CH_A_UP   = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_F_UP   = 8'h46;
  localparam logic [CHAR_WIDTH-1:0] HEX_ALPHA = 8'd10;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_FIRST  = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_DEC    = 6'b010000,
    PH_HEX    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    logic                 emit;
    logic [OUT_WIDTH-1:0] value;
  } parse_result_t;

endpackage

FILE: hw/rtl/asip_in_if.sv
`timescale 1ns / 1ps
// Input channel of the integer parser: one character per transfer.
// Depends on asip_pkg for the character width.
interface asip_in_if;
  logic                            valid;
  logic                            ready;
  logic [asip_pkg::CHAR_WIDTH-1:0] char_code;
  logic                            start_of_string;

  modport source (output valid, output char_code, output start_of_string, input ready);
  modport sink (input valid, input char_code, input start_of_string, output ready);
endinterface

FILE: hw/rtl/asip_out_if.sv
`timescale 1ns / 1ps
// Result channel of the integer parser: one parsed value per transfer.
// Depends on asip_pkg for the output width.
interface asip_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [asip_pkg::OUT_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

FILE: hw/rtl/ascii_signed_int_parser.sv
`timescale 1ns / 1ps
// Top level of the ASCII signed integer parser: handshake and result register.
// Depends on asip_pkg, asip_in_if, asip_out_if, asip_decode and asip_parse.
//
//   Channel   Direction  Payload                       Meaning
//   in_chan   sink       char_code, start_of_string    one character per transfer
//   out_chan  source     value (signed 32 bits)        one value per finished number
//
// One character is taken per cycle; its state update and any result are done in
// that cycle, and the value appears on out_chan in the cycle after the transfer.
// Throughput is set by the result register: a new character is taken while that
// register is empty or its value is being taken in the same cycle.
// Reset is synchronous and active low, and leaves the parser idle with no result.
// A stall on out_chan holds the result and the input until the value is taken.
module ascii_signed_int_parser (
  input  logic       clk,
  input  logic       rst_n,
  asip_in_if.sink    in_chan,
  asip_out_if.source out_chan
);

  asip_pkg::char_class_t               char_class;
  asip_pkg::parse_result_t             result;
  logic                                accept;
  logic                                out_valid_r, out_valid_nxt;
  logic [asip_pkg::OUT_WIDTH-1:0]      value_r;

  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign accept         = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.value = value_r;

  asip_decode u_decode (
    .char_code  (in_chan.char_code),
    .char_class (char_class)
  );

  asip_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .start_of_string (in_chan.start_of_string),
    .char_class      (char_class),
    .result          (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = result.emit;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.emit) begin
      value_r <= result.value;
    end
  end

endmodule

FILE: hw/rtl/asip_decode.sv
`timescale 1ns / 1ps
// Character classifier: sign, zero, x marker, decimal and hex digit values.
// Depends on asip_pkg.
module asip_decode (
  input  logic [asip_pkg::CHAR_WIDTH-1:0] char_code,
  output asip_pkg::char_class_t           char_class
);

  logic [asip_pkg::CHAR_WIDTH-1:0] digit_wide;

  always_comb begin
    char_class          = '0;
    digit_wide          = '0;
    char_class.is_minus = (char_code == asip_pkg::CH_MINUS);
    char_class.is_zero  = (char_code == asip_pkg::CH_ZERO);
    char_class.is_x     = (char_code == asip_pkg::CH_X_LOW) || (char_code == asip_pkg::CH_X_UP);
    if (char_code inside {[asip_pkg::CH_ZERO:asip_pkg::CH_NINE]}) begin
      char_class.dec_ok = 1'b1;
      char_class.hex_ok = 1'b1;
      digit_wide        = char_code - asip_pkg::CH_ZERO;
    end else if (char_code inside {[asip_pkg::CH_A_LOW:asip_pkg::CH_F_LOW]}) begin
      char_class.hex_ok = 1'b1;
      digit_wide        = char_code - asip_pkg::CH_A_LOW + asip_pkg::HEX_ALPHA;
    end else if (char_code inside {[asip_pkg::CH_A_UP:asip_pkg::CH_F_UP]}) begin
      char_class.hex_ok = 1'b1;
      digit_wide        = char_code - asip_pkg::CH_A_UP + asip_pkg::HEX_ALPHA;
    end
    char_class.digit = digit_wide[3:0];
  end

endmodule

FILE: hw/rtl/asip_parse.sv
`timescale 1ns / 1ps
// Parse state machine: phase, accumulator and sign, updated once per accepted
// character, with the signed result formed on the terminating one. Depends on asip_pkg.
module asip_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          start_of_string,
  input  asip_pkg::char_class_t         char_class,
  output asip_pkg::parse_result_t       result
);

  localparam int unsigned VW = asip_pkg::VALUE_WIDTH;
  localparam int unsigned OW = asip_pkg::OUT_WIDTH;

  asip_pkg::phase_t phase_r, phase_nxt, phase_eff;
  logic [VW-1:0]    acc_r, acc_nxt, acc_eff;
  logic             neg_r, neg_nxt, neg_eff;
  logic [VW-1:0]    acc_dec, acc_hex, mag;
  logic [VW+OW-1:0] mag_ext;
  logic             dec_emit;

  assign phase_eff = start_of_string ? asip_pkg::PH_FIRST : phase_r;
  assign acc_eff   = start_of_string ? '0 : acc_r;
  assign neg_eff   = start_of_string ? 1'b0 : neg_r;

  assign acc_dec = (acc_eff << 3) + (acc_eff << 1) + VW'(char_class.digit);
  assign acc_hex = (acc_eff << 4) + VW'(char_class.digit);

  assign mag     = neg_eff ? (~acc_eff + VW'(1)) : acc_eff;
  assign mag_ext = {{OW{mag[VW-1]}}, mag};

  always_comb begin
    phase_nxt    = phase_eff;
    acc_nxt      = acc_eff;
    neg_nxt      = neg_eff;
    dec_emit     = 1'b0;
    result.emit  = 1'b0;
    result.value = mag_ext[OW-1:0];
    case (phase_eff)
      asip_pkg::PH_FIRST, asip_pkg::PH_SIGNED: begin
        if ((phase_eff == asip_pkg::PH_FIRST) && char_class.is_minus) begin
          neg_nxt   = 1'b1;
          phase_nxt = asip_pkg::PH_SIGNED;
        end else if (char_class.is_zero) begin
          acc_nxt   = '0;
          phase_nxt = asip_pkg::PH_ZERO;
        end else begin
          dec_emit = 1'b1;
        end
      end
      asip_pkg::PH_ZERO: begin
        if (char_class.is_x) begin
          phase_nxt = asip_pkg::PH_HEX;
        end else begin
          dec_emit = 1'b1;
        end
      end
      asip_pkg::PH_DEC: begin
        dec_emit = 1'b1;
      end
      asip_pkg::PH_HEX: begin
        if (char_class.hex_ok) begin
          acc_nxt = acc_hex;
        end else begin
          result.emit = 1'b1;
          phase_nxt   = asip_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = asip_pkg::PH_IDLE;
      end
    endcase
    if (dec_emit) begin
      if (char_class.dec_ok) begin
        acc_nxt   = acc_dec;
        phase_nxt = asip_pkg::PH_DEC;
      end else begin
        result.emit = 1'b1;
        phase_nxt   = asip_pkg::PH_IDLE;
      end
    end
    if (!accept) begin
      result.emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= asip_pkg::PH_IDLE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
    end
  end

endmodule

FILE: dv/tb_ascii_signed_int_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for ascii_signed_int_parser: directed corner cases, random
// well-formed numbers and random noise, with random gaps on both channels.
// Depends on asip_pkg, asip_in_if, asip_out_if and the parser RTL.
module tb_ascii_signed_int_parser;
  import asip_pkg::*;

  typedef logic [CHAR_WIDTH-1:0] char_t;

  logic clk = 1'b0;
  logic rst_n;

  asip_in_if  in_chan ();
  asip_out_if out_chan ();

  ascii_signed_int_parser dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always #6 clk = ~clk;

  logic signed [OUT_WIDTH-1:0] expected_values[$];
  int unsigned                 fail_count = 0;
  bit                          gaps_enabled = 1'b1;

  phase_t                      parser_phase = PH_IDLE;
  logic [VALUE_WIDTH-1:0]      parser_acc = '0;
  logic                        parser_neg = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic int digit_value(char_t c, bit hex_base);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (!hex_base) return -1;
    if (c >= CH_A_LOW && c <= CH_F_LOW) return int'(c - CH_A_LOW) + int'(HEX_ALPHA);
    if (c >= CH_A_UP && c <= CH_F_UP) return int'(c - CH_A_UP) + int'(HEX_ALPHA);
    return -1;
  endfunction

  // Advances the parser state by one character and reports any finished value.
  function automatic void parse_char(input char_t c, input bit sos, output bit done,
                                     output logic signed [OUT_WIDTH-1:0] value);
    int dec_d;
    int hex_d;
    bit finish;
    dec_d  = digit_value(c, 1'b0);
    hex_d  = digit_value(c, 1'b1);
    finish = 1'b0;
    done   = 1'b0;
    value  = '0;
    if (sos) begin
      parser_phase = PH_FIRST;
      parser_acc   = '0;
      parser_neg   = 1'b0;
    end
    case (parser_phase)
      PH_FIRST, PH_SIGNED, PH_ZERO, PH_DEC: begin
        if (parser_phase == PH_FIRST && c == CH_MINUS) begin
          parser_neg   = 1'b1;
          parser_phase = PH_SIGNED;
        end else if ((parser_phase == PH_FIRST || parser_phase == PH_SIGNED) &&
                     c == CH_ZERO) begin
          parser_acc   = '0;
          parser_phase = PH_ZERO;
        end else if (parser_phase == PH_ZERO && (c == CH_X_LOW || c == CH_X_UP)) begin
          parser_phase = PH_HEX;
        end else if (dec_d >= 0) begin
          parser_acc   = parser_acc * 10 + VALUE_WIDTH'(dec_d);
          parser_phase = PH_DEC;
        end else begin
          finish = 1'b1;
        end
      end
      PH_HEX: begin
        if (hex_d >= 0) begin
          parser_acc = parser_acc * 16 + VALUE_WIDTH'(hex_d);
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
        parser_phase = PH_IDLE;
      end
    endcase
    if (finish) begin
      done         = 1'b1;
      value        = parser_neg ? -parser_acc : parser_acc;
      parser_phase = PH_IDLE;
    end
  endfunction

  task automatic send_char(input char_t c, input bit sos);
    int gap;
    bit done;
    logic signed [OUT_WIDTH-1:0] value;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.char_code       <= c;
    in_chan.start_of_string <= sos;
    do @(posedge clk); while (!in_chan.ready);
    parse_char(c, sos, done, value);
    if (done) expected_values.push_back(value);
  endtask

  task automatic send_text(input char_t text[$]);
    foreach (text[i]) send_char(text[i], i == 0);
  endtask

  function automatic char_t random_digit(bit hex_base);
    int v;
    v = hex_base ? $urandom_range(0, 15) : $urandom_range(0, 9);
    if (v < 10) return CH_ZERO + char_t'(v);
    return ($urandom_range(0, 1) ? CH_A_LOW : CH_A_UP) + char_t'(v - 10);
  endfunction

  function automatic char_t random_terminator(bit hex_base);
    char_t c;
    if ($urandom_range(0, 9) < 4) return 8'h00;
    do c = char_t'($urandom_range(0, 255)); while (digit_value(c, hex_base) >= 0);
    return c;
  endfunction

  task automatic send_random_number(output int sent);
    char_t text[$];
    bit    hex_base;
    int    r;
    int    n_digits;
    hex_base = $urandom_range(0, 2) == 0;
    r = $urandom_range(0, 99);
    n_digits = r < 15 ? $urandom_range(0, 1) :
               r < 75 ? $urandom_range(2, 6) : $urandom_range(7, 12);
    if ($urandom_range(0, 2) == 0) text.push_back(CH_MINUS);
    if (hex_base) begin
      text.push_back(CH_ZERO);
      text.push_back($urandom_range(0, 1) ? CH_X_LOW : CH_X_UP);
    end
    repeat (n_digits) text.push_back(random_digit(hex_base));
    // A few numbers are left unfinished so that the next start drops them.
    if ($urandom_range(0, 9) != 0) text.push_back(random_terminator(hex_base));
    if (text.size() == 0) text.push_back(random_terminator(hex_base));
    send_text(text);
    sent = text.size();
  endtask

  task automatic test_directed_cases();
    send_char("A", 1'b0);
    send_text('{CH_MINUS, CH_X_LOW});
    send_text('{";"});
    send_text('{CH_ZERO, CH_X_UP, 8'h00});
    send_text('{CH_MINUS, CH_ZERO, CH_X_LOW, "f", "F", "g"});
    send_text('{CH_ZERO, "7", " "});
    send_char("9", 1'b1);
    send_char("5", 1'b1);
    send_char(8'hFF, 1'b0);
    send_text('{CH_MINUS, "9", "A"});
  endtask

  task automatic test_well_formed_numbers(input int n_chars);
    int total;
    int sent;
    total = 0;
    while (total < n_chars) begin
      send_random_number(sent);
      total += sent;
    end
  endtask

  task automatic test_back_to_back(input int n_chars);
    gaps_enabled = 1'b0;
    test_well_formed_numbers(n_chars);
    gaps_enabled = 1'b1;
  endtask

  task automatic test_noise(input int n_chars);
    char_t picks[$];
    char_t c;
    picks = '{CH_MINUS, CH_ZERO, CH_X_LOW, CH_X_UP, "5", "a", "F", 8'h00};
    repeat (n_chars) begin
      if ($urandom_range(0, 2) == 0) c = picks[$urandom_range(0, picks.size() - 1)];
      else c = char_t'($urandom_range(0, 255));
      send_char(c, $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected value transfer, expected none, actual %0d",
                 $time, out_chan.value);
        fail_count++;
      end else begin
        if (out_chan.value !== expected_values[0]) begin
          $display("%0t: value mismatch, expected %0d, actual %0d",
                   $time, expected_values[0], out_chan.value);
          fail_count++;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  initial begin
    rst_n                   <= 1'b0;
    in_chan.valid           <= 1'b0;
    in_chan.char_code       <= '0;
    in_chan.start_of_string <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_well_formed_numbers(375);
    test_back_to_back(150);
    test_noise(150);
    test_well_formed_numbers(50);

    in_chan.valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d values outstanding", $time, expected_values.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/asip_pkg.sv
hw/rtl/asip_in_if.sv
hw/rtl/asip_out_if.sv
hw/rtl/asip_decode.sv
hw/rtl/asip_parse.sv
hw/rtl/ascii_signed_int_parser.sv
dv/tb_ascii_signed_int_parser.sv
